@@ design/tgfe_pkg.sv @@
// Shared types, register indexes and the output quantizer for the touch gesture feature extractor.
package tgfe_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_INV_SCALE  = 2'd0;
    localparam logic [1:0] CFG_ZERO_POINT = 2'd1;
    localparam logic [1:0] CFG_WINDOW     = 2'd2;
    localparam logic [1:0] CFG_TURN_THR   = 2'd3;

    // Register reset values
    localparam logic [15:0]       INV_SCALE_RST  = 16'd65280;
    localparam logic signed [7:0] ZERO_POINT_RST = -8'sd128;
    localparam logic [15:0]       WINDOW_RST     = 16'd2000;
    localparam logic [7:0]        TURN_THR_RST   = 8'd2;

    // Normalization constants (scaled to integers)
    localparam logic signed [19:0] OCC_NUM_SCALE = 20'sd100000;
    localparam logic signed [19:0] OCC_OFFSET    = 20'sd1500;
    localparam logic signed [19:0] OCC_SPAN      = 20'sd73375;
    localparam logic [33:0]        HOLD_SPAN     = 34'd2935;
    localparam logic [33:0]        REST_SPAN     = 34'd2370;
    localparam logic signed [51:0] HOLD_OFFSET   = 52'sd60;
    localparam logic signed [51:0] REST_OFFSET   = 52'sd65;
    localparam logic [16:0]        Q16_ONE       = 17'd65536;
    localparam int                 DIV_STEPS     = 17;

    typedef struct packed {
        logic       contact;
        logic [8:0] pos_x;
        logic [7:0] pos_y;
        logic [31:0] time_ms;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] feat_occupancy;
        logic signed [7:0] feat_transitions;
        logic signed [7:0] feat_longest_hold;
        logic signed [7:0] feat_active_time;
        logic signed [7:0] feat_rest_before;
        logic signed [7:0] feat_rest_after;
        logic [31:0]       gesture_duration_ms;
        logic [7:0]        turn_count;
    } feat_t;

    // Add the zero point in Q8.24, round halves away from zero, saturate to int8
    function automatic logic signed [7:0] quantise(input logic [32:0] prod,
                                                   input logic signed [7:0] zp);
        logic signed [35:0] s;
        logic [35:0]        mag;
        logic [11:0]        qm;
        logic signed [12:0] q;
        logic signed [7:0]  r;
        s = $signed({3'b000, prod}) + ($signed({{28{zp[7]}}, zp}) <<< 24);
        if (s[35])
        begin
            mag = $unsigned(-s) + 36'd8388608;
        end
        else
        begin
            mag = $unsigned(s) + 36'd8388608;
        end
        qm = mag[35:24];
        q  = s[35] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        if (q > 13'sd127)
        begin
            r = 8'sd127;
        end
        else if (q < -13'sd128)
        begin
            r = -8'sd128;
        end
        else
        begin
            r = q[7:0];
        end
        return r;
    endfunction

endpackage

@@ design/tgfe_mul.sv @@
// Shared signed multiplier with a registered product.
module tgfe_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [19:0] b,
    output logic signed [51:0] prod
);
    logic signed [51:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(a) * 52'(b);
    end

    assign prod = prod_reg;
endmodule

@@ design/tgfe_div.sv @@
// Bit-serial fractional divider: floor(num * 2^17 / den) for 0 < num < den.
module tgfe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] num,
    input  logic [33:0] den,
    output logic        done,
    output logic [16:0] quo
);
    import tgfe_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [33:0] den_reg;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [34:0] trial;

    // One quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, 1'b0};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            quo_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 34'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

@@ design/touch_gesture_feature_extractor.sv @@
// Touch gesture feature extractor: one touch sample per item, one feature set per release.
// A contact sample with no turn test to run, or a poll outside a gesture, is handled in the idle state.
// A contact sample with a nonzero step after an earlier nonzero step runs the exact
// dot-product turn test, which sends eight products through one shared 33x20 multiplier.
// A release builds the occupancy ratio from three products, then each of three normalized
// features that lands strictly inside (0,1) goes through a 17-step serial divider, and four
// products through the same multiplier quantize the features, the rest-after one from zero.
// The result waits in an output register; the next sample is taken while it waits.
module touch_gesture_feature_extractor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  tgfe_pkg::sample_t sample,
    output logic              feat_valid,
    input  logic              feat_stall,
    output tgfe_pkg::feat_t   feat,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import tgfe_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE   = 23'd1 << 0,
        S_T0     = 23'd1 << 1,
        S_T1     = 23'd1 << 2,
        S_T2     = 23'd1 << 3,
        S_T3     = 23'd1 << 4,
        S_T4     = 23'd1 << 5,
        S_T5     = 23'd1 << 6,
        S_T6     = 23'd1 << 7,
        S_T7     = 23'd1 << 8,
        S_T8     = 23'd1 << 9,
        S_R0     = 23'd1 << 10,
        S_R1     = 23'd1 << 11,
        S_R2     = 23'd1 << 12,
        S_R3     = 23'd1 << 13,
        S_DSTART = 23'd1 << 14,
        S_DWAIT  = 23'd1 << 15,
        S_Q0     = 23'd1 << 16,
        S_Q1     = 23'd1 << 17,
        S_Q2     = 23'd1 << 18,
        S_Q3     = 23'd1 << 19,
        S_Q4     = 23'd1 << 20,
        S_Q5     = 23'd1 << 21,
        S_OUT    = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [15:0]       inv_scale_reg;
    logic signed [7:0] zero_point_reg;
    logic [15:0]       window_reg;
    logic [7:0]        turn_thr_reg;

    // Gesture state
    logic              in_contact_reg;
    logic [31:0]       start_time_reg;
    logic [31:0]       last_time_reg;
    logic [8:0]        last_x_reg;
    logic [7:0]        last_y_reg;
    logic signed [9:0] last_dx_reg;
    logic signed [8:0] last_dy_reg;
    logic              dir_valid_reg;
    logic [7:0]        turns_reg;
    logic [31:0]       gest_end_reg;

    // Working registers
    logic signed [9:0]  dx_reg;
    logic signed [8:0]  dy_reg;
    logic signed [51:0] acc_reg;
    logic signed [19:0] dot_reg;
    logic [18:0]        ma_reg;
    logic [18:0]        mb_reg;
    logic [31:0]        dur_reg;
    logic [31:0]        rest_reg;
    logic [7:0]         tc_reg;
    logic               trans_reg;
    logic signed [51:0] occ_num_reg;
    logic [33:0]        occ_den_reg;
    logic [1:0]         nidx_reg;
    logic [16:0]        v_occ_reg;
    logic [16:0]        v_hold_reg;
    logic [16:0]        v_rest_reg;
    logic signed [7:0]  q_occ_reg;
    logic signed [7:0]  q_trans_reg;
    logic signed [7:0]  q_hold_reg;
    logic signed [7:0]  q_rest_reg;
    logic signed [7:0]  q_after_reg;
    logic               feat_valid_reg;
    feat_t              feat_reg;

    // Shared units
    logic signed [32:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [51:0] prod;
    logic               div_start;
    logic [33:0]        div_num;
    logic [33:0]        div_den;
    logic               div_done;
    logic [16:0]        div_quo;

    tgfe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    tgfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic               accept;
    logic [8:0]         eff_lx;
    logic [7:0]         eff_ly;
    logic signed [9:0]  step_dx;
    logic signed [8:0]  step_dy;
    logic               step_nz;
    logic [15:0]        win_eff;
    logic signed [51:0] num_sel;
    logic [33:0]        den_sel;
    logic               num_pos;
    logic               num_ge;
    logic [17:0]        v_round;
    logic signed [7:0]  q_now;
    logic               out_free;
    logic               turn_hit;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_free     = !feat_valid_reg || !feat_stall;

    // Step vector against the previous point of this contact
    assign eff_lx  = in_contact_reg ? last_x_reg : sample.pos_x;
    assign eff_ly  = in_contact_reg ? last_y_reg : sample.pos_y;
    assign step_dx = $signed({1'b0, sample.pos_x}) - $signed({1'b0, eff_lx});
    assign step_dy = $signed({1'b0, sample.pos_y}) - $signed({1'b0, eff_ly});
    assign step_nz = (step_dx != 10'sd0) || (step_dy != 9'sd0);
    assign win_eff = (window_reg == 16'd0) ? 16'd1 : window_reg;

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T0:
            begin
                mul_a = 33'(last_dx_reg);
                mul_b = 20'(dx_reg);
            end
            S_T1:
            begin
                mul_a = 33'(last_dy_reg);
                mul_b = 20'(dy_reg);
            end
            S_T2:
            begin
                mul_a = 33'(last_dx_reg);
                mul_b = 20'(last_dx_reg);
            end
            S_T3:
            begin
                mul_a = 33'(last_dy_reg);
                mul_b = 20'(last_dy_reg);
            end
            S_T4:
            begin
                mul_a = 33'(dx_reg);
                mul_b = 20'(dx_reg);
            end
            S_T5:
            begin
                mul_a = 33'(dy_reg);
                mul_b = 20'(dy_reg);
            end
            S_T6:
            begin
                mul_a = 33'(dot_reg);
                mul_b = dot_reg;
            end
            S_T7:
            begin
                mul_a = $signed({14'd0, ma_reg});
                mul_b = $signed({1'b0, mb_reg});
            end
            S_R0:
            begin
                mul_a = $signed({1'b0, dur_reg});
                mul_b = OCC_NUM_SCALE;
            end
            S_R1:
            begin
                mul_a = $signed({17'd0, win_eff});
                mul_b = OCC_OFFSET;
            end
            S_R2:
            begin
                mul_a = $signed({17'd0, win_eff});
                mul_b = OCC_SPAN;
            end
            S_Q0:
            begin
                mul_a = $signed({16'd0, v_occ_reg});
                mul_b = $signed({4'd0, inv_scale_reg});
            end
            S_Q1:
            begin
                mul_a = $signed({16'd0, (trans_reg ? Q16_ONE : 17'd0)});
                mul_b = $signed({4'd0, inv_scale_reg});
            end
            S_Q2:
            begin
                mul_a = $signed({16'd0, v_hold_reg});
                mul_b = $signed({4'd0, inv_scale_reg});
            end
            S_Q3:
            begin
                mul_a = $signed({16'd0, v_rest_reg});
                mul_b = $signed({4'd0, inv_scale_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Select the ratio to normalize
    always_comb
    begin
        case (nidx_reg)
            2'd0:
            begin
                num_sel = occ_num_reg;
                den_sel = occ_den_reg;
            end
            2'd1:
            begin
                num_sel = $signed({20'd0, dur_reg} << 1) - HOLD_OFFSET;
                den_sel = HOLD_SPAN;
            end
            default:
            begin
                num_sel = $signed({20'd0, rest_reg} << 1) - REST_OFFSET;
                den_sel = REST_SPAN;
            end
        endcase
        num_pos   = !num_sel[51] && (num_sel != 52'sd0);
        num_ge    = num_sel >= $signed({18'd0, den_sel});
        div_num   = num_sel[33:0];
        div_den   = den_sel;
        div_start = (state_reg == S_DSTART) && num_pos && !num_ge;
    end

    // Round the Q0.17 quotient to Q0.16
    assign v_round  = {1'b0, div_quo} + 18'd1;
    assign q_now    = quantise(prod[32:0], zero_point_reg);
    assign turn_hit = (dot_reg <= 20'sd0) || ((acc_reg <<< 1) < prod);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.contact)
                    begin
                        if (step_nz && in_contact_reg && dir_valid_reg)
                        begin
                            state_next = S_T0;
                        end
                    end
                    else if (in_contact_reg)
                    begin
                        state_next = S_R0;
                    end
                end
            end
            S_T0:     state_next = S_T1;
            S_T1:     state_next = S_T2;
            S_T2:     state_next = S_T3;
            S_T3:     state_next = S_T4;
            S_T4:     state_next = S_T5;
            S_T5:     state_next = S_T6;
            S_T6:     state_next = S_T7;
            S_T7:     state_next = S_T8;
            S_T8:     state_next = S_IDLE;
            S_R0:     state_next = S_R1;
            S_R1:     state_next = S_R2;
            S_R2:     state_next = S_R3;
            S_R3:     state_next = S_DSTART;
            S_DSTART:
            begin
                if (div_start)
                begin
                    state_next = S_DWAIT;
                end
                else if (nidx_reg == 2'd2)
                begin
                    state_next = S_Q0;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (nidx_reg == 2'd2) ? S_Q0 : S_DSTART;
                end
            end
            S_Q0:     state_next = S_Q1;
            S_Q1:     state_next = S_Q2;
            S_Q2:     state_next = S_Q3;
            S_Q3:     state_next = S_Q4;
            S_Q4:     state_next = S_Q5;
            S_Q5:     state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold control state, configuration and gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inv_scale_reg  <= INV_SCALE_RST;
            zero_point_reg <= ZERO_POINT_RST;
            window_reg     <= WINDOW_RST;
            turn_thr_reg   <= TURN_THR_RST;
            in_contact_reg <= 1'b0;
            start_time_reg <= '0;
            last_time_reg  <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_dx_reg    <= '0;
            last_dy_reg    <= '0;
            dir_valid_reg  <= 1'b0;
            turns_reg      <= '0;
            gest_end_reg   <= '0;
            nidx_reg       <= '0;
            feat_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                    CFG_ZERO_POINT: zero_point_reg <= $signed(cfg_data[7:0]);
                    CFG_WINDOW:     window_reg     <= cfg_data;
                    CFG_TURN_THR:   turn_thr_reg   <= cfg_data[7:0];
                endcase
            end

            // Track contact and release
            if (state_reg == S_IDLE && accept)
            begin
                if (sample.contact)
                begin
                    if (!in_contact_reg)
                    begin
                        start_time_reg <= sample.time_ms;
                        turns_reg      <= '0;
                        dir_valid_reg  <= 1'b0;
                    end
                    in_contact_reg <= 1'b1;
                    last_x_reg     <= sample.pos_x;
                    last_y_reg     <= sample.pos_y;
                    last_time_reg  <= sample.time_ms;
                    if (step_nz && !(in_contact_reg && dir_valid_reg))
                    begin
                        last_dx_reg   <= step_dx;
                        last_dy_reg   <= step_dy;
                        dir_valid_reg <= 1'b1;
                    end
                end
                else if (in_contact_reg)
                begin
                    in_contact_reg <= 1'b0;
                    gest_end_reg   <= sample.time_ms;
                    turns_reg      <= '0;
                    dir_valid_reg  <= 1'b0;
                end
            end

            // Count the turn and keep the new direction
            if (state_reg == S_T8)
            begin
                if (turn_hit && turns_reg != 8'd255)
                begin
                    turns_reg <= turns_reg + 8'd1;
                end
                last_dx_reg <= dx_reg;
                last_dy_reg <= dy_reg;
            end

            // Step through the three normalized ratios
            if (state_reg == S_R3)
            begin
                nidx_reg <= '0;
            end
            else if ((state_reg == S_DSTART && !div_start) ||
                     (state_reg == S_DWAIT && div_done))
            begin
                nidx_reg <= nidx_reg + 2'd1;
            end

            // Hold the result until taken
            if (state_reg == S_OUT && out_free)
            begin
                feat_valid_reg <= 1'b1;
            end
            else if (!feat_stall)
            begin
                feat_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            dx_reg    <= step_dx;
            dy_reg    <= step_dy;
            dur_reg   <= last_time_reg - start_time_reg;
            rest_reg  <= (start_time_reg > gest_end_reg) ? start_time_reg - gest_end_reg : '0;
            tc_reg    <= turns_reg;
            trans_reg <= (turns_reg >= turn_thr_reg);
        end

        unique case (state_reg)
            S_T1:    acc_reg     <= prod;
            S_T2:    dot_reg     <= 20'(acc_reg + prod);
            S_T3:    acc_reg     <= prod;
            S_T4:    ma_reg      <= 19'(acc_reg + prod);
            S_T5:    acc_reg     <= prod;
            S_T6:    mb_reg      <= 19'(acc_reg + prod);
            S_T7:    acc_reg     <= prod;
            S_R1:    acc_reg     <= prod;
            S_R2:    occ_num_reg <= acc_reg - prod;
            S_R3:    occ_den_reg <= prod[33:0];
            S_Q1:    q_occ_reg   <= q_now;
            S_Q2:    q_trans_reg <= q_now;
            S_Q3:    q_hold_reg  <= q_now;
            S_Q4:    q_rest_reg  <= q_now;
            S_Q5:    q_after_reg <= q_now;
            default:
            begin
            end
        endcase

        // Store each normalized value
        if ((state_reg == S_DSTART && !div_start) || (state_reg == S_DWAIT && div_done))
        begin
            case (nidx_reg)
                2'd0:
                begin
                    v_occ_reg <= (state_reg == S_DWAIT) ? v_round[17:1] :
                                 (num_pos ? Q16_ONE : 17'd0);
                end
                2'd1:
                begin
                    v_hold_reg <= (state_reg == S_DWAIT) ? v_round[17:1] :
                                  (num_pos ? Q16_ONE : 17'd0);
                end
                default:
                begin
                    v_rest_reg <= (state_reg == S_DWAIT) ? v_round[17:1] :
                                  (num_pos ? Q16_ONE : 17'd0);
                end
            endcase
        end

        // Load the output register
        if (state_reg == S_OUT && out_free)
        begin
            feat_reg.feat_occupancy      <= q_occ_reg;
            feat_reg.feat_transitions    <= q_trans_reg;
            feat_reg.feat_longest_hold   <= q_hold_reg;
            feat_reg.feat_active_time    <= q_hold_reg;
            feat_reg.feat_rest_before    <= q_rest_reg;
            feat_reg.feat_rest_after     <= q_after_reg;
            feat_reg.gesture_duration_ms <= dur_reg;
            feat_reg.turn_count          <= tc_reg;
        end
    end

    assign feat_valid = feat_valid_reg;
    assign feat       = feat_reg;
endmodule

@@ dv/touch_gesture_feature_extractor_tb.sv @@
// Testbench for the touch gesture feature extractor: directed table, then random gestures.
module touch_gesture_feature_extractor_tb;
    import tgfe_pkg::*;

    localparam int GESTURE_TARGET = 1850;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        feat_valid;
    logic        feat_stall;
    feat_t       feat;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor state and configuration
    logic [15:0]        m_inv_scale;
    logic signed [7:0]  m_zero_point;
    logic [15:0]        m_window;
    logic [7:0]         m_turn_thr;
    logic               m_in_contact;
    logic [31:0]        m_start_time;
    logic [31:0]        m_last_time;
    logic [8:0]         m_last_x;
    logic [7:0]         m_last_y;
    logic signed [9:0]  m_step_dx;
    logic signed [8:0]  m_step_dy;
    logic               m_dir_valid;
    logic [7:0]         m_turns;
    logic [31:0]        m_gesture_end;

    feat_t       pending_features[$];
    int          error_count;
    int          items_sent;
    int          features_seen;
    int          idle_cycles;
    bit          hold_off_req;
    bit          fill_done;
    logic [31:0] clock_ms;

    touch_gesture_feature_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .feat_valid   (feat_valid),
        .feat_stall   (feat_stall),
        .feat         (feat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Clip num/den to [0,1] in Q0.16, rounded half up
    function automatic logic [16:0] norm_q16(input longint num, input longint den);
        if (num <= 0)
        begin
            return 17'd0;
        end
        if (num >= den)
        begin
            return Q16_ONE;
        end
        return 17'(((num << 17) + den) / (den * 2));
    endfunction

    // Scale, add zero point, round half away from zero, saturate to int8
    function automatic logic signed [7:0] quantize_feature(input logic [16:0] v);
        longint s;
        longint q;
        s = longint'(v) * longint'(m_inv_scale) + longint'(m_zero_point) * 64'sd16777216;
        if (s >= 0)
        begin
            q = (s + 8388608) / 16777216;
        end
        else
        begin
            q = -((-s + 8388608) / 16777216);
        end
        if (q < -128)
        begin
            q = -128;
        end
        if (q > 127)
        begin
            q = 127;
        end
        return 8'(q);
    endfunction

    // Advance the predictor by one sample; queue a feature set on release
    task automatic predict_sample(input sample_t s);
        logic [31:0] dur;
        logic [31:0] rest;
        longint      w;
        longint      dx;
        longint      dy;
        longint      dot;
        longint      ma;
        longint      mb;
        bit          turn;
        feat_t       f;
        if (!s.contact)
        begin
            if (m_in_contact)
            begin
                m_in_contact = 1'b0;
                dur  = m_last_time - m_start_time;
                rest = (m_start_time > m_gesture_end) ? m_start_time - m_gesture_end : 32'd0;
                w    = (m_window == 16'd0) ? 1 : longint'(m_window);
                f.feat_occupancy = quantize_feature(
                    norm_q16(longint'(dur) * 100000 - w * 1500, w * 73375));
                f.feat_transitions = quantize_feature((m_turns >= m_turn_thr) ? Q16_ONE : 17'd0);
                f.feat_longest_hold = quantize_feature(norm_q16(longint'(dur) * 2 - 60, 2935));
                f.feat_active_time = f.feat_longest_hold;
                f.feat_rest_before = quantize_feature(norm_q16(longint'(rest) * 2 - 65, 2370));
                f.feat_rest_after = quantize_feature(17'd0);
                f.gesture_duration_ms = dur;
                f.turn_count = m_turns;
                pending_features.push_back(f);
                m_gesture_end = s.time_ms;
                m_turns = 8'd0;
                m_dir_valid = 1'b0;
            end
            return;
        end
        if (!m_in_contact)
        begin
            m_in_contact = 1'b1;
            m_start_time = s.time_ms;
            m_last_x = s.pos_x;
            m_last_y = s.pos_y;
            m_turns = 8'd0;
            m_dir_valid = 1'b0;
        end
        dx = longint'(s.pos_x) - longint'(m_last_x);
        dy = longint'(s.pos_y) - longint'(m_last_y);
        if (dx != 0 || dy != 0)
        begin
            if (m_dir_valid)
            begin
                dot = longint'(m_step_dx) * dx + longint'(m_step_dy) * dy;
                if (dot <= 0)
                begin
                    turn = 1'b1;
                end
                else
                begin
                    ma = longint'(m_step_dx) * m_step_dx + longint'(m_step_dy) * m_step_dy;
                    mb = dx * dx + dy * dy;
                    turn = (2 * dot * dot) < (ma * mb);
                end
                if (turn && m_turns != 8'd255)
                begin
                    m_turns = m_turns + 8'd1;
                end
            end
            m_step_dx = 10'(dx);
            m_step_dy = 9'(dy);
            m_dir_valid = 1'b1;
        end
        m_last_x = s.pos_x;
        m_last_y = s.pos_y;
        m_last_time = s.time_ms;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Drive one sample and wait for it to be taken; valid stays up for a following item
    task automatic send_sample(input sample_t s);
        sample       <= s;
        sample_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (sample_stall);
        predict_sample(s);
        items_sent++;
        @(negedge clk);
    endtask

    // Same as send_sample but with a random gap afterwards
    task automatic offer_sample(input sample_t s);
        int gap;
        send_sample(s);
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
              (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_features.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_INV_SCALE:  m_inv_scale  = value;
            CFG_ZERO_POINT: m_zero_point = value[7:0];
            CFG_WINDOW:     m_window     = value;
            CFG_TURN_THR:   m_turn_thr   = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic sample_t make_sample(input bit c, input int x, input int y,
                                            input logic [31:0] t);
        sample_t s;
        s.contact = c;
        s.pos_x   = 9'(x);
        s.pos_y   = 8'(y);
        s.time_ms = t;
        return s;
    endfunction

    // One gesture: touch-down, a random walk or random jumps, release
    task automatic random_gesture();
        int x;
        int y;
        int steps;
        int mode;
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
        mode  = $urandom_range(0, 3);
        x = $urandom_range(0, 320);
        y = $urandom_range(0, 239);
        clock_ms = clock_ms + (($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000));
        offer_sample(make_sample(1'b1, x, y, clock_ms));
        for (int k = 0; k < steps; k++)
        begin
            if (mode == 0)
            begin
                x = $urandom_range(0, 511);
                y = $urandom_range(0, 255);
            end
            else
            begin
                x = x + $urandom_range(0, 6) - 3;
                y = y + $urandom_range(0, 6) - 3;
                x = (x < 0) ? 0 : ((x > 320) ? 320 : x);
                y = (y < 0) ? 0 : ((y > 239) ? 239 : y);
            end
            clock_ms = clock_ms + (($urandom_range(0, 30) == 0) ? $urandom :
                                   $urandom_range(0, 200));
            offer_sample(make_sample(1'b1, x, y, clock_ms));
        end
        clock_ms = clock_ms + $urandom_range(0, 50);
        offer_sample(make_sample(1'b0, $urandom_range(0, 511), $urandom_range(0, 255),
                                 clock_ms));
        if ($urandom_range(0, 9) == 0)
        begin
            // a stray poll outside any gesture
            offer_sample(make_sample(1'b0, $urandom_range(0, 511), $urandom_range(0, 255),
                                     $urandom));
        end
    endtask

    // Directed table: contact, x, y, time
    typedef struct {
        bit          contact;
        int          x;
        int          y;
        logic [31:0] t;
    } step_row_t;

    step_row_t directed_rows[] = '{
        '{1'b0, 0, 0, 32'd100},            // release with no gesture
        '{1'b1, 0, 0, 32'd1000},           // first sample
        '{1'b1, 0, 0, 32'd1010},           // zero step
        '{1'b1, 10, 0, 32'd1020},
        '{1'b1, 20, 10, 32'd1030},         // exactly 45 degrees
        '{1'b1, 20, 20, 32'd1040},         // 45 again, not a turn
        '{1'b1, 10, 20, 32'd1050},         // 90 degrees
        '{1'b1, 20, 20, 32'd1060},         // reversal
        '{1'b1, 320, 239, 32'd1070},
        '{1'b1, 0, 0, 32'd1080},
        '{1'b0, 511, 255, 32'd5000},
        '{1'b1, 511, 255, 32'hFFFF_FFF0},  // long rest, coordinates at field max
        '{1'b1, 0, 0, 32'h0000_0010},      // time wraps
        '{1'b0, 0, 0, 32'h0000_0020},
        '{1'b1, 5, 5, 32'd0},              // start before last end: rest clamps to 0
        '{1'b1, 6, 5, 32'hFFFF_FFFF},
        '{1'b0, 0, 0, 32'hFFFF_FFFF}
    };

    // Result checker
    always @(posedge clk)
    begin
        feat_t want;
        if (rst_n && feat_valid && !feat_stall)
        begin
            features_seen++;
            if (pending_features.size() == 0)
            begin
                report_mismatch("unexpected feature set", 1, 0);
            end
            else
            begin
                want = pending_features.pop_front();
                if (feat.feat_occupancy != want.feat_occupancy)
                    report_mismatch("occupancy", feat.feat_occupancy, want.feat_occupancy);
                if (feat.feat_transitions != want.feat_transitions)
                    report_mismatch("transitions", feat.feat_transitions, want.feat_transitions);
                if (feat.feat_longest_hold != want.feat_longest_hold)
                    report_mismatch("longest_hold", feat.feat_longest_hold,
                                    want.feat_longest_hold);
                if (feat.feat_active_time != want.feat_active_time)
                    report_mismatch("active_time", feat.feat_active_time, want.feat_active_time);
                if (feat.feat_rest_before != want.feat_rest_before)
                    report_mismatch("rest_before", feat.feat_rest_before, want.feat_rest_before);
                if (feat.feat_rest_after != want.feat_rest_after)
                    report_mismatch("rest_after", feat.feat_rest_after, want.feat_rest_after);
                if (feat.gesture_duration_ms != want.gesture_duration_ms)
                    report_mismatch("duration", feat.gesture_duration_ms,
                                    want.gesture_duration_ms);
                if (feat.turn_count != want.turn_count)
                    report_mismatch("turn_count", feat.turn_count, want.turn_count);
            end
        end
    end

    // Receiver stall: random gaps, plus one long hold-off on request
    initial
    begin
        int len;
        feat_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                feat_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
                fill_done = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) :
                      $urandom_range(1, 3);
                feat_stall <= 1'b1;
                repeat (len - 1) @(negedge clk);
            end
            else
            begin
                feat_stall <= 1'b0;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
                repeat (len) @(negedge clk);
            end
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (feat_valid && !feat_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        sample_t s;
        feat_t   want;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_INV_SCALE;
        cfg_data     = '0;
        error_count  = 0;
        items_sent   = 0;
        features_seen = 0;
        idle_cycles  = 0;
        hold_off_req = 1'b0;
        fill_done    = 1'b0;
        clock_ms     = 32'd0;
        m_inv_scale  = INV_SCALE_RST;
        m_zero_point = ZERO_POINT_RST;
        m_window     = WINDOW_RST;
        m_turn_thr   = TURN_THR_RST;
        m_in_contact = 1'b0;
        m_start_time = '0;
        m_last_time  = '0;
        m_last_x     = '0;
        m_last_y     = '0;
        m_step_dx    = '0;
        m_step_dy    = '0;
        m_dir_valid  = 1'b0;
        m_turns      = '0;
        m_gesture_end = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table at reset configuration
        foreach (directed_rows[i])
        begin
            s = make_sample(directed_rows[i].contact, directed_rows[i].x, directed_rows[i].y,
                            directed_rows[i].t);
            send_sample(s);
            // the first release at reset settings: 80 ms, three turns, fixed constants
            if (i == 10)
            begin
                want = pending_features[pending_features.size() - 1];
                if (want.gesture_duration_ms != 32'd80 || want.turn_count != 8'd3 ||
                    want.feat_transitions != 8'sd127 || want.feat_rest_after != -8'sd128)
                begin
                    report_mismatch("directed release", want.turn_count, 3);
                end
            end
        end
        wait_idle();

        // Configuration phases, extremes first
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(CFG_INV_SCALE, 16'hFFFF);
                    write_register(CFG_ZERO_POINT, 16'h007F);
                    write_register(CFG_WINDOW, 16'd0);
                    write_register(CFG_TURN_THR, 16'd0);
                end
                1:
                begin
                    write_register(CFG_INV_SCALE, 16'd0);
                    write_register(CFG_ZERO_POINT, 16'hFF80);
                    write_register(CFG_WINDOW, 16'hFFFF);
                    write_register(CFG_TURN_THR, 16'd255);
                end
                2:
                begin
                    write_register(CFG_INV_SCALE, INV_SCALE_RST);
                    write_register(CFG_ZERO_POINT, 16'(ZERO_POINT_RST));
                    write_register(CFG_WINDOW, WINDOW_RST);
                    write_register(CFG_TURN_THR, TURN_THR_RST);
                end
                default:
                begin
                    write_register(CFG_INV_SCALE, 16'($urandom));
                    write_register(CFG_ZERO_POINT, 16'($urandom));
                    write_register(CFG_WINDOW, 16'($urandom_range(1, 65535)));
                    write_register(CFG_TURN_THR, 16'($urandom_range(0, 8)));
                end
            endcase
            cfg_valid <= 1'b0;
            if (phase == 1)
            begin
                // saturate the turn counter with a long zig-zag
                offer_sample(make_sample(1'b1, 100, 100, clock_ms));
                for (int k = 0; k < 300; k++)
                begin
                    offer_sample(make_sample(1'b1, (k % 2) ? 100 : 110, 100, clock_ms + k));
                end
                offer_sample(make_sample(1'b0, 0, 0, clock_ms + 400));
                clock_ms = clock_ms + 400;
            end
            if (phase == 3)
            begin
                // long receiver hold-off while gestures keep coming
                hold_off_req = 1'b1;
                while (!fill_done)
                begin
                    random_gesture();
                end
            end
            while (items_sent < (phase + 1) * (GESTURE_TARGET / 6))
            begin
                random_gesture();
                if ($urandom_range(0, 40) == 0)
                begin
                    // pause until everything is out
                    sample_valid <= 1'b0;
                    do
                    begin
                        @(negedge clk);
                    end
                    while (pending_features.size() != 0);
                end
            end
            wait_idle();
        end

        $display("Sent %0d samples, checked %0d feature sets over six register settings",
                 items_sent, features_seen);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
